FILE: hw/rtl/annexb_start_code_nal_splitter_core_macros.svh
// assertion macros for the checker file asns_checker.sv
// each expects clk and arst_n in the scope where it is used
`ifndef ANNEXB_START_CODE_NAL_SPLITTER_CORE_MACROS_SVH
`define ANNEXB_START_CODE_NAL_SPLITTER_CORE_MACROS_SVH

// same-cycle implication
`define ASNS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASNS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/asns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package asns_pkg;

	localparam int BYTE_W = 8;
	localparam int OFF_W = 24;
	localparam int LEN_W = 3;
	localparam int TYPE_W = 5;
	localparam int SIZE_W = 25;
	localparam int QUEUE_DEPTH = 4;

	// start code lengths, none found is zero
	localparam logic [LEN_W-1:0] SC_NONE = 3'd0;
	localparam logic [LEN_W-1:0] SC_SHORT = 3'd3;
	localparam logic [LEN_W-1:0] SC_LONG = 3'd4;

	// per-byte command from the scanner to the unit tracker
	typedef struct packed {
		logic found;
		logic [LEN_W-1:0] len;
		logic hdr_valid;
		logic [TYPE_W-1:0] hdr_type;
		logic last;
	} cmd_ctl_t;

	typedef struct packed {
		logic [OFF_W-1:0] unit_offset;
		logic [LEN_W-1:0] code_length;
		logic [TYPE_W-1:0] unit_type;
		logic [SIZE_W-1:0] unit_size;
		logic packet_done;
		logic no_units;
	} res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/asns_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface asns_byte_if;
	import asns_pkg::*;

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] byte_value;
	logic last_byte;

	modport source(output valid, output byte_value, output last_byte, input ready);
	modport sink(input valid, input byte_value, input last_byte, output ready);
	modport monitor(input valid, input byte_value, input last_byte, input ready);
endinterface
`default_nettype wire

FILE: hw/rtl/asns_unit_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface asns_unit_if;
	import asns_pkg::*;

	logic valid;
	logic ready;
	logic [OFF_W-1:0] unit_offset;
	logic [LEN_W-1:0] code_length;
	logic [TYPE_W-1:0] unit_type;
	logic [SIZE_W-1:0] unit_size;
	logic packet_done;
	logic no_units;

	modport source(output valid, output unit_offset, output code_length, output unit_type,
		output unit_size, output packet_done, output no_units, input ready);
	modport sink(input valid, input unit_offset, input code_length, input unit_type,
		input unit_size, input packet_done, input no_units, output ready);
	modport monitor(input valid, input unit_offset, input code_length, input unit_type,
		input unit_size, input packet_done, input no_units, input ready);
endinterface
`default_nettype wire

FILE: hw/rtl/annexb_start_code_nal_splitter_core.sv
// a result passes through the queue and the output register before it shows on units
// a second result from the same byte waits in the hold stage and follows the first
// throughput: one byte per cycle while the queue is not full, set by the scanner and queue write
// the output side takes one result per cycle from its register while units is ready
// reset: arst_n clears scanner, position, queue and unit tracker at once, no sweep
`timescale 1ns / 1ps
`default_nettype none
module annexb_start_code_nal_splitter_core #(
	parameter longint unsigned MAX_PACKET_BYTES = 64'd16777216
) (
	input logic clk,
	input logic arst_n,
	asns_byte_if.sink bytes,
	asns_unit_if.source units
);
	import asns_pkg::*;

	// packet position width, saturates at the last index
	localparam int POS_W = $clog2(MAX_PACKET_BYTES);
	// queue word: control struct, start offset and byte count so far
	localparam int CMD_W = $bits(cmd_ctl_t) + POS_W + POS_W + 1;

	// front side: scanner output toward the queue
	logic cmd_push;
	cmd_ctl_t wr_ctl;
	logic [POS_W-1:0] wr_off;
	logic [POS_W:0] wr_total;
	logic cmd_full;

	// back side: queue head toward the unit tracker
	logic [CMD_W-1:0] rd_data;
	cmd_ctl_t rd_ctl;
	logic [POS_W-1:0] rd_off;
	logic [POS_W:0] rd_total;
	logic cmd_valid;
	logic cmd_pop;

	// scanner: finds start codes, tracks position and the header byte,
	// pushes one command per byte that matters (start code, header, packet end)
	asns_front #(
		.POS_W(POS_W),
		.MAX_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd_ctl(wr_ctl),
		.cmd_off(wr_off),
		.cmd_total(wr_total)
	);

	// short queue lets the scanner keep taking bytes while results stall
	asns_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_push),
		.wr_data({wr_ctl, wr_off, wr_total}),
		.rd_en(cmd_pop),
		.rd_data(rd_data),
		.full(cmd_full),
		.not_empty(cmd_valid)
	);

	assign {rd_ctl, rd_off, rd_total} = rd_data;

	// unit tracker: holds the open unit, sizes it and emits up to two
	// results per command through an output register and a hold stage
	asns_back #(
		.POS_W(POS_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd_ctl(rd_ctl),
		.cmd_off(rd_off),
		.cmd_total(rd_total),
		.units(units)
	);
endmodule
`default_nettype wire

FILE: hw/rtl/asns_front.sv
`timescale 1ns / 1ps
`default_nettype none
module asns_front #(
	parameter int POS_W = 24,
	parameter longint unsigned MAX_BYTES = 64'd16777216
) (
	input logic clk,
	input logic arst_n,
	asns_byte_if.sink bytes,
	input logic cmd_full,
	output logic cmd_push,
	output asns_pkg::cmd_ctl_t cmd_ctl,
	output logic [POS_W-1:0] cmd_off,
	output logic [POS_W:0] cmd_total
);
	import asns_pkg::*;

	typedef enum logic [1:0] {ZEROS_NONE, ZEROS_ONE, ZEROS_TWO, ZEROS_THREE} phase_t;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BYTES - 64'd1);

	phase_t phase_q, phase_d;
	logic [POS_W-1:0] pos_q;
	logic awaiting_q;
	logic accept;
	logic is_zero, is_one;
	logic [LEN_W-1:0] found_len;
	logic found;
	logic [POS_W-1:0] back_dist;

	assign bytes.ready = !cmd_full;
	assign accept = bytes.valid && bytes.ready;
	assign is_zero = (bytes.byte_value == BYTE_W'(0));
	assign is_one = (bytes.byte_value == BYTE_W'(1));

	always_comb begin
		phase_d = ZEROS_NONE;
		found_len = SC_NONE;
		case (phase_q)
			ZEROS_NONE: begin
				if (is_zero) phase_d = ZEROS_ONE;
			end
			ZEROS_ONE: begin
				if (is_zero) phase_d = ZEROS_TWO;
			end
			ZEROS_TWO: begin
				if (is_zero) phase_d = ZEROS_THREE;
				else if (is_one) found_len = SC_SHORT;
			end
			ZEROS_THREE: begin
				// anything but 01 drops back, a further zero too
				if (is_one) found_len = SC_LONG;
			end
			default: phase_d = ZEROS_NONE;
		endcase
	end

	assign found = (found_len != SC_NONE);
	assign back_dist = (found_len == SC_LONG) ? POS_W'(SC_LONG - 3'd1)
		: POS_W'(SC_SHORT - 3'd1);
	assign cmd_off = (pos_q >= back_dist) ? pos_q - back_dist : '0;
	assign cmd_total = {1'b0, pos_q} + (POS_W+1)'(1);

	assign cmd_ctl.found = found;
	assign cmd_ctl.len = found_len;
	assign cmd_ctl.hdr_valid = awaiting_q;
	assign cmd_ctl.hdr_type = bytes.byte_value[TYPE_W-1:0];
	assign cmd_ctl.last = bytes.last_byte;
	assign cmd_push = accept && (found || awaiting_q || bytes.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ZEROS_NONE;
			pos_q <= '0;
			awaiting_q <= 1'b0;
		end else if (accept) begin
			if (bytes.last_byte) begin
				phase_q <= ZEROS_NONE;
				pos_q <= '0;
				awaiting_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q <= (pos_q == POS_LAST) ? pos_q : pos_q + POS_W'(1);
				awaiting_q <= found;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/asns_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module asns_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic full,
	output logic not_empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr, do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && not_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/asns_back.sv
`timescale 1ns / 1ps
`default_nettype none
module asns_back #(
	parameter int POS_W = 24
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_pop,
	input asns_pkg::cmd_ctl_t cmd_ctl,
	input logic [POS_W-1:0] cmd_off,
	input logic [POS_W:0] cmd_total,
	asns_unit_if.source units
);
	import asns_pkg::*;

	logic pend_valid_q;
	logic [POS_W-1:0] pend_off_q;
	logic [LEN_W-1:0] pend_len_q;
	logic [TYPE_W-1:0] pend_type_q;
	logic out_valid_q, hold_valid_q;
	res_t out_q, hold_q;

	logic load_ok;
	logic emit_a, emit_b;
	logic [TYPE_W-1:0] type_h;
	logic [POS_W:0] end_old, end_new, off_ext, size_a, size_b;
	logic new_valid;
	logic [POS_W-1:0] new_off;
	logic [LEN_W-1:0] new_len;
	logic [TYPE_W-1:0] new_type;
	res_t res_a, res_b;

	assign load_ok = !out_valid_q || units.ready;
	assign cmd_pop = cmd_valid && load_ok && !hold_valid_q;

	// header byte lands on the unit found before it
	assign type_h = cmd_ctl.hdr_valid ? cmd_ctl.hdr_type : pend_type_q;

	assign off_ext = {1'b0, cmd_off};
	assign end_old = {1'b0, pend_off_q} + (POS_W+1)'(pend_len_q);
	assign size_a = (off_ext > end_old) ? off_ext - end_old : '0;
	assign emit_a = cmd_ctl.found && pend_valid_q;

	always_comb begin
		res_a.unit_offset = OFF_W'(pend_off_q);
		res_a.code_length = pend_len_q;
		res_a.unit_type = (size_a == '0) ? '0 : type_h;
		res_a.unit_size = SIZE_W'(size_a);
		res_a.packet_done = 1'b0;
		res_a.no_units = 1'b0;
	end

	assign new_valid = pend_valid_q || cmd_ctl.found;
	assign new_off = cmd_ctl.found ? cmd_off : pend_off_q;
	assign new_len = cmd_ctl.found ? cmd_ctl.len : pend_len_q;
	assign new_type = cmd_ctl.found ? '0 : type_h;
	assign end_new = {1'b0, new_off} + (POS_W+1)'(new_len);
	assign size_b = (cmd_total > end_new) ? cmd_total - end_new : '0;
	assign emit_b = cmd_ctl.last;

	always_comb begin
		if (new_valid) begin
			res_b.unit_offset = OFF_W'(new_off);
			res_b.code_length = new_len;
			res_b.unit_type = new_type;
			res_b.unit_size = SIZE_W'(size_b);
			res_b.no_units = 1'b0;
		end else begin
			res_b.unit_offset = '0;
			res_b.code_length = SC_NONE;
			res_b.unit_type = '0;
			res_b.unit_size = '0;
			res_b.no_units = 1'b1;
		end
		res_b.packet_done = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) pend_valid_q <= new_valid && !cmd_ctl.last;
			if (hold_valid_q && load_ok) begin
				out_valid_q <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (cmd_pop) begin
				out_valid_q <= emit_a || emit_b;
				hold_valid_q <= emit_a && emit_b;
			end else if (load_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pend_off_q <= new_off;
			pend_len_q <= new_len;
			pend_type_q <= new_type;
		end
		if (hold_valid_q && load_ok) begin
			out_q <= hold_q;
		end else if (cmd_pop) begin
			out_q <= emit_a ? res_a : res_b;
			hold_q <= res_b;
		end
	end

	assign units.valid = out_valid_q;
	assign units.unit_offset = out_q.unit_offset;
	assign units.code_length = out_q.code_length;
	assign units.unit_type = out_q.unit_type;
	assign units.unit_size = out_q.unit_size;
	assign units.packet_done = out_q.packet_done;
	assign units.no_units = out_q.no_units;
endmodule
`default_nettype wire

FILE: hw/rtl/asns_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "annexb_start_code_nal_splitter_core_macros.svh"
module asns_checker (
	input logic clk,
	input logic arst_n,
	asns_unit_if.source units
);
	import asns_pkg::*;

	logic unit_stall;
	logic [OFF_W+SIZE_W-1:0] unit_key;
	logic empty_form;
	logic len_ok;

	assign unit_stall = units.valid && !units.ready;
	assign unit_key = {units.unit_offset, units.unit_size};
	assign empty_form = units.packet_done && (units.unit_offset == '0) && (units.unit_size == '0);
	assign len_ok = (units.code_length == SC_SHORT) || (units.code_length == SC_LONG);

	// a stalled result keeps its offset and size
	`ASNS_ASSERT_NEXT(a_hold_stall, unit_stall, units.valid && $stable(unit_key), "result changed while stalled")

	// empty packet result carries only the flags
	`ASNS_ASSERT_NOW(a_no_units_form, units.valid && units.no_units, empty_form, "malformed no-units result")

	// a real unit has a three or four byte start code
	`ASNS_ASSERT_NOW(a_code_len, units.valid && !units.no_units, len_ok, "bad start code length")

	// a typed unit always has payload
	`ASNS_ASSERT_NOW(a_type_size, units.valid && units.unit_type != '0, units.unit_size != '0, "typed unit with zero size")
endmodule

bind annexb_start_code_nal_splitter_core asns_checker u_asns_checker (
	.clk(clk),
	.arst_n(arst_n),
	.units(units)
);
`default_nettype wire
